/* rtl/core/svisc_pkg.sv */
// Shared constants and register index codes for the Sutherland viscosity block.
package svisc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF        = 2'd0,
        CFG_EFF_TEMP    = 2'd1,
        CFG_DENOM_FLOOR = 2'd2
    } cfg_idx_t;

endpackage

/* rtl/core/svisc_temp_if.sv */
// Temperature channel: valid/ready handshake with one temperature per transaction.
interface svisc_temp_if
    import svisc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

/* rtl/core/svisc_visc_if.sv */
// Viscosity channel: valid/ready handshake with one result per transaction.
interface svisc_visc_if
    import svisc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] viscosity;
    logic                 saturated;

    modport source (output valid, output viscosity, output saturated, input ready);
    modport sink   (input valid, input viscosity, input saturated, output ready);
endinterface

/* rtl/core/svisc_sqrt.sv */
// Pipelined integer square root of the temperature in QF, one root bit per stage.
module svisc_sqrt
    import svisc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RootW    = (WORD_BITS + FRAC_BITS + 1) / 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] in_temp,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_temp,
    output logic [RootW-1:0]     out_root
);

    localparam int RadW = 2 * RootW;
    localparam int RemW = RootW + 2;
    localparam int ShW  = RootW + 3;

    logic                 v_reg    [RootW];
    logic [WORD_BITS-1:0] t_reg    [RootW];
    logic [RadW-1:0]      x_reg    [RootW];
    logic [RootW-1:0]     root_reg [RootW];
    logic [RemW-1:0]      rem_reg  [RootW];

    for (genvar i = 0; i < RootW; i++)
    begin : g_stage
        logic                 v_in;
        logic [WORD_BITS-1:0] t_in;
        logic [RadW-1:0]      x_in;
        logic [RootW-1:0]     root_in;
        logic [RemW-1:0]      rem_in;
        logic [ShW-1:0]       rem_sh;
        logic [ShW-1:0]       trial;
        logic                 ge;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign t_in    = in_temp;
            assign x_in    = RadW'({in_temp, {FRAC_BITS{1'b0}}});
            assign root_in = '0;
            assign rem_in  = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[i-1];
            assign t_in    = t_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rem_in  = rem_reg[i-1];
        end

        // bring down the next radicand pair and try the next root bit
        assign rem_sh = {rem_in[RootW:0], x_in[RadW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[i]    <= t_in;
                x_reg[i]    <= x_in << 2;
                root_reg[i] <= {root_in[RootW-2:0], ge};
                rem_reg[i]  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
            end
        end
    end

    assign out_valid = v_reg[RootW-1];
    assign out_temp  = t_reg[RootW-1];
    assign out_root  = root_reg[RootW-1];

endmodule

/* rtl/core/svisc_div.sv */
// Pipelined restoring divider with overflow detect, one quotient bit per stage.
module svisc_div
    import svisc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int NUM_BITS  = 2 * WORD_BITS_DEF,
    localparam int DenW     = WORD_BITS + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  in_num,
    input  logic [DenW-1:0]      in_den,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_quot,
    output logic                 out_ovf
);

    localparam int HiW  = NUM_BITS - WORD_BITS;
    localparam int CmpW = (HiW > DenW) ? HiW : DenW;

    logic [CmpW-1:0]      hi_ext;
    logic [CmpW-1:0]      den_ext;
    logic                 e_ovf;

    logic                 ev_reg;
    logic                 eovf_reg;
    logic [DenW-1:0]      erem_reg;
    logic [DenW-1:0]      eden_reg;
    logic [WORD_BITS-1:0] elo_reg;

    logic                 v_reg   [WORD_BITS];
    logic                 ovf_reg [WORD_BITS];
    logic [DenW-1:0]      rem_reg [WORD_BITS];
    logic [DenW-1:0]      den_reg [WORD_BITS];
    logic [WORD_BITS-1:0] lo_reg  [WORD_BITS];
    logic [WORD_BITS-1:0] q_reg   [WORD_BITS];

    // quotient reaches 2^W exactly when the upper part is at least the divisor
    assign hi_ext  = CmpW'(in_num[NUM_BITS-1:WORD_BITS]);
    assign den_ext = CmpW'(in_den);
    assign e_ovf   = (hi_ext >= den_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
        end
        else if (en)
        begin
            ev_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eovf_reg <= e_ovf;
            erem_reg <= e_ovf ? '0 : hi_ext[DenW-1:0];
            eden_reg <= in_den;
            elo_reg  <= in_num[WORD_BITS-1:0];
        end
    end

    for (genvar j = 0; j < WORD_BITS; j++)
    begin : g_stage
        logic                 v_in;
        logic                 ovf_in;
        logic [DenW-1:0]      rem_in;
        logic [DenW-1:0]      den_in;
        logic [WORD_BITS-1:0] lo_in;
        logic [WORD_BITS-1:0] q_in;
        logic [DenW:0]        rem_sh;
        logic [DenW:0]        den_sh;
        logic                 ge;

        if (j == 0)
        begin : g_first
            assign v_in   = ev_reg;
            assign ovf_in = eovf_reg;
            assign rem_in = erem_reg;
            assign den_in = eden_reg;
            assign lo_in  = elo_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = v_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign rem_sh = {rem_in, lo_in[WORD_BITS-1]};
        assign den_sh = {1'b0, den_in};
        assign ge     = (rem_sh >= den_sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[j] <= ovf_in;
                rem_reg[j] <= ge ? DenW'(rem_sh - den_sh) : rem_sh[DenW-1:0];
                den_reg[j] <= den_in;
                lo_reg[j]  <= lo_in << 1;
                q_reg[j]   <= {q_in[WORD_BITS-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[WORD_BITS-1];
    assign out_ovf   = ovf_reg[WORD_BITS-1];
    assign out_quot  = ovf_reg[WORD_BITS-1] ? '1 : q_reg[WORD_BITS-1];

endmodule

/* rtl/core/sutherland_viscosity.sv */
// Sutherland viscosity law: viscosity = coef * T * sqrt(T) / max(floor, T + S), fixed point.
// Pipeline: RootW square root stages, RootW = (WORD_BITS + FRAC_BITS + 1) / 2, then multiply and divide stages;
//   at the default Q16.16, 24 root stages, 3 multiply stages and 33 divide stages.
// Throughput: one temperature per cycle; the whole pipe advances together and holds
//   as one while the result register waits on a stalled sink.
// Reset: rst_n clears every stage valid bit and loads coef = 1.0, S = 0, floor = 1 LSB.
module sutherland_viscosity
    import svisc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_BITS-1:0]  cfg_data,
    svisc_temp_if.sink            sample,
    svisc_visc_if.source          result
);

    localparam int RootW = (WORD_BITS + FRAC_BITS + 1) / 2;
    localparam int ProdW = WORD_BITS + RootW;          // T * sqrt(T) before rescale
    localparam int PW    = ProdW - FRAC_BITS;          // T^1.5 in QF
    localparam int LoW   = PW / 2;                     // split of the coef multiply
    localparam int HiW   = PW - LoW;
    localparam int NumW  = PW + WORD_BITS;             // exact coef * T^1.5
    localparam int DenW  = WORD_BITS + 1;
    localparam int FlW   = FRAC_BITS + 1;

    // ---------------------------------------------------------------
    // Configuration registers; bits above a register's width drop.
    // ---------------------------------------------------------------
    logic [WORD_BITS-1:0] coef_reg;
    logic [WORD_BITS-1:0] eff_reg;
    logic [FlW-1:0]       floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= WORD_BITS'(1) << FRAC_BITS;
            eff_reg   <= '0;
            floor_reg <= FlW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF:        coef_reg  <= cfg_data;
                CFG_EFF_TEMP:    eff_reg   <= cfg_data;
                CFG_DENOM_FLOOR: floor_reg <= cfg_data[FlW-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipe advance: every stage moves when the result register is
    // empty or its transaction completes this cycle.
    // ---------------------------------------------------------------
    logic en;

    assign en           = !result.valid || result.ready;
    assign sample.ready = en;

    // ---------------------------------------------------------------
    // Square root stages: floor(sqrt(T << F)), T carried alongside.
    // ---------------------------------------------------------------
    logic                 sq_valid;
    logic [WORD_BITS-1:0] sq_temp;
    logic [RootW-1:0]     sq_root;

    svisc_sqrt #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .in_temp   (sample.temperature),
        .out_valid (sq_valid),
        .out_temp  (sq_temp),
        .out_root  (sq_root)
    );

    // ---------------------------------------------------------------
    // M1: T * sqrt(T), and the clamped denominator.
    // ---------------------------------------------------------------
    logic [DenW-1:0] den_sum;
    logic [DenW-1:0] den_fl;
    logic [DenW-1:0] den_next;

    logic             m1_v_reg;
    logic [ProdW-1:0] prod_reg;
    logic [DenW-1:0]  den1_reg;

    // a zero floor acts as one LSB so the divisor is never zero
    assign den_sum  = {1'b0, sq_temp} + {1'b0, eff_reg};
    assign den_fl   = (floor_reg == '0) ? DenW'(1) : DenW'(floor_reg);
    assign den_next = (den_sum < den_fl) ? den_fl : den_sum;

    // ---------------------------------------------------------------
    // M2: coef times each half of T^1.5.
    // ---------------------------------------------------------------
    logic [PW-1:0]            p_q;
    logic                     m2_v_reg;
    logic [HiW+WORD_BITS-1:0] pp_hi_reg;
    logic [LoW+WORD_BITS-1:0] pp_lo_reg;
    logic [DenW-1:0]          den2_reg;

    assign p_q = prod_reg[ProdW-1:FRAC_BITS];

    // ---------------------------------------------------------------
    // M3: recombine the partial products into the exact numerator.
    // ---------------------------------------------------------------
    logic             m3_v_reg;
    logic [NumW-1:0]  num_reg;
    logic [DenW-1:0]  den3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= sq_valid;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= ProdW'(sq_temp) * ProdW'(sq_root);
            den1_reg  <= den_next;
            pp_hi_reg <= (HiW+WORD_BITS)'(p_q[PW-1:LoW]) * (HiW+WORD_BITS)'(coef_reg);
            pp_lo_reg <= (LoW+WORD_BITS)'(p_q[LoW-1:0]) * (LoW+WORD_BITS)'(coef_reg);
            den2_reg  <= den1_reg;
            num_reg   <= (NumW'(pp_hi_reg) << LoW) + NumW'(pp_lo_reg);
            den3_reg  <= den2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Divide stages; the last one is the result register.
    // ---------------------------------------------------------------
    svisc_div #(
        .WORD_BITS (WORD_BITS),
        .NUM_BITS  (NumW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m3_v_reg),
        .in_num    (num_reg),
        .in_den    (den3_reg),
        .out_valid (result.valid),
        .out_quot  (result.viscosity),
        .out_ovf   (result.saturated)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |-> (result.viscosity == '1))
        else $error("saturated result is not all ones");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m1_v_reg |-> (den1_reg != '0))
        else $error("zero divisor entered the pipe");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |=> $stable(m3_v_reg) && $stable(m1_v_reg))
        else $error("pipe stage moved during a stall");

endmodule
